// File: rtl/core/rsi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the ray/sphere intersection pipeline
// no dependencies; imported by every module of the block
package rsi_pkg;

  // coordinate format and unit vector scaling
  localparam int FRAC_BITS = 16;
  localparam int UNIT_FRAC = 30;

  // radius after reset: 1.0 in coordinate units
  localparam logic [30:0] RADIUS_RESET = 31'(32'd1 << FRAC_BITS);

  // iterative units: one result bit per step, steps grouped into stages
  localparam int STEPS_PER_STAGE = 2;
  localparam int ROOT_STEPS      = 32;
  localparam int DIV_STEPS       = 32;
  localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

  // input word: one ray
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] heading_x;
    logic signed [31:0] heading_y;
    logic signed [31:0] heading_z;
  } ray_t;

  // output word: hit flag and intersection point
  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } hit_t;

endpackage

// File: rtl/core/rsi_isqrt.sv
`timescale 1ns / 1ps
// pipelined floor square root of a 64-bit value, two root bits per stage
// depends on rsi_pkg for the stage count
module rsi_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] radicand_i,
  output logic [31:0] root_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_st_t;

  // one restoring step: bring down two radicand bits, try 4r+1
  function automatic sq_st_t sq_step(sq_st_t s);
    logic [34:0] rem_n;
    logic [34:0] trial;
    sq_st_t      r;
    rem_n = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r     = s;
    r.rad = {s.rad[61:0], 2'b00};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  sq_st_t init;
  sq_st_t st_in [ROOT_STEPS];
  sq_st_t st_c  [ROOT_STEPS];
  sq_st_t st_q  [ROOT_STAGES];

  assign init = '{rem: '0, root: '0, rad: radicand_i};

  // step chain, cut by a register after every group of steps
  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
    if (i % STEPS_PER_STAGE == 0) begin : g_head
      if (i == 0) begin : g_in
        assign st_in[i] = init;
      end else begin : g_reg
        assign st_in[i] = st_q[i / STEPS_PER_STAGE - 1];
      end
    end else begin : g_chain
      assign st_in[i] = st_c[i - 1];
    end
    assign st_c[i] = sq_step(st_in[i]);
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_STAGES; k++) begin
        st_q[k] <= st_c[(k + 1) * STEPS_PER_STAGE - 1];
      end
    end
  end

  assign root_o = st_q[ROOT_STAGES - 1].root;

endmodule

// File: rtl/core/rsi_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, 62-bit dividend by 32-bit divisor
// two quotient bits per stage; depends on rsi_pkg for the stage count
module rsi_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] numer_i,
  input  logic [31:0] denom_i,
  output logic [30:0] quot_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] num;
    logic [31:0] den;
  } dv_st_t;

  // one step: shift in a dividend bit, subtract when it fits
  function automatic dv_st_t dv_step(dv_st_t s);
    logic [32:0] rem_n;
    dv_st_t      r;
    rem_n = {s.rem, s.num[31]};
    r     = s;
    r.num = {s.num[30:0], 1'b0};
    if (rem_n >= {1'b0, s.den}) begin
      r.rem = 32'(rem_n - {1'b0, s.den});
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = rem_n[31:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  dv_st_t init;
  dv_st_t st_in [DIV_STEPS];
  dv_st_t st_c  [DIV_STEPS];
  dv_st_t st_q  [DIV_STAGES];

  // upper dividend bits are always below the divisor
  assign init = '{rem: {2'b00, numer_i[61:32]}, quo: '0, num: numer_i[31:0], den: denom_i};

  // step chain, cut by a register after every group of steps
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    if (i % STEPS_PER_STAGE == 0) begin : g_head
      if (i == 0) begin : g_in
        assign st_in[i] = init;
      end else begin : g_reg
        assign st_in[i] = st_q[i / STEPS_PER_STAGE - 1];
      end
    end else begin : g_chain
      assign st_in[i] = st_c[i - 1];
    end
    assign st_c[i] = dv_step(st_in[i]);
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_q[k] <= st_c[(k + 1) * STEPS_PER_STAGE - 1];
      end
    end
  end

  assign quot_o = st_q[DIV_STAGES - 1].quo[30:0];

endmodule

// File: rtl/core/ray_sphere_intersection.sv
`timescale 1ns / 1ps
// ray against origin-centered sphere, fully pipelined
// depends on rsi_pkg, rsi_isqrt and rsi_div
//
// Usage:
//   in channel (in_valid_i / in_stall_o / in_word_i) takes one ray per word:
//   origin and heading, signed Q16.16. out channel (out_valid_o /
//   out_stall_i / out_word_o) returns one word per ray: hit flag and the
//   nearest intersection at positive distance, saturated, zero on a miss.
//   The user must write the radius register through cfg_we_i / cfg_wdata_i
//   only while no ray is in flight; the block does not enforce it. Reset
//   loads radius 1.0. One ray is accepted every cycle unless out_stall_i
//   holds the output word; the depth comes from the heading length square
//   root, the three unit vector dividers and the discriminant square root,
//   each at two bits per stage (16 stages apiece).
//   Reset clears all valid bits, so the pipeline starts empty.
//   While the output word is held by out_stall_i the whole pipeline freezes
//   and in_stall_o is raised; bubbles move with the data and nothing is
//   lost or repeated.
module ray_sphere_intersection (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rsi_pkg::ray_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rsi_pkg::hit_t out_word_o,
  input  logic          cfg_we_i,
  input  logic [30:0]   cfg_wdata_i
);
  import rsi_pkg::*;

  localparam int LAT = 5 + ROOT_STAGES + 1 + DIV_STAGES + 6 + ROOT_STAGES + 3;

  // stage payloads
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] hm;
    logic [2:0]       neg;
  } sa_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] hm;
    logic [2:0]       neg;
    logic [4:0]       sh;
    logic             zero;
  } sb_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] hn;
    logic [2:0]       neg;
    logic             zero;
  } sc_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] hn;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][63:0] sq;
  } sd_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] hn;
    logic [2:0]       neg;
    logic             zero;
  } fr_t;

  typedef struct packed {
    logic [2:0][61:0] num;
    logic [31:0]      len;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } sf_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } dv_t;

  typedef struct packed {
    logic [2:0][30:0] umag;
    logic [2:0][63:0] psq;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } sg_t;

  typedef struct packed {
    logic [2:0][63:0] prod;
    logic [63:0]      p;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } sh_t;

  typedef struct packed {
    logic [63:0]      dot;
    logic [63:0]      p;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } si_t;

  typedef struct packed {
    logic [34:0]      beta;
    logic [31:0]      bm;
    logic [63:0]      p;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } sj_t;

  typedef struct packed {
    logic [34:0]      beta;
    logic [63:0]      q;
    logic [63:0]      p;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             zero;
  } sk_t;

  typedef struct packed {
    logic [63:0]      d;
    logic [34:0]      beta;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             miss;
  } sl_t;

  typedef struct packed {
    logic [34:0]      beta;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
    logic             miss;
  } bk_t;

  typedef struct packed {
    logic [33:0]      t;
    logic             hit;
    logic [2:0][30:0] umag;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
  } sm_t;

  typedef struct packed {
    logic [2:0][64:0] prod;
    logic             hit;
    logic [2:0][31:0] o;
    logic [2:0]       neg;
  } sn_t;

  logic [LAT-1:0] vld_q;
  logic           adv;
  logic [30:0]    radius_q;
  logic [61:0]    r2_q;

  sa_t sa_d, sa_q;
  sb_t sb_d, sb_q;
  sc_t sc_d, sc_q;
  sd_t sd_d, sd_q;
  fr_t se_d, se_q;
  logic [63:0] sumsq_d, sumsq_q;
  fr_t fr_dl_q [ROOT_STAGES];
  sf_t sf_d, sf_q;
  dv_t dv_dl_q [DIV_STAGES];
  sg_t sg_d, sg_q;
  sh_t sh_d, sh_q;
  si_t si_d, si_q;
  sj_t sj_d, sj_q;
  sk_t sk_d, sk_q;
  sl_t sl_d, sl_q;
  bk_t bk_dl_q [ROOT_STAGES];
  sm_t sm_d, sm_q;
  sn_t sn_d, sn_q;
  hit_t out_d, out_q;

  logic [31:0]      len;
  logic [31:0]      sq2;
  logic [2:0][30:0] quot;

  // whole pipeline moves unless the output word is held
  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];
  assign out_word_o  = out_q;

  // valid bits and radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= RADIUS_RESET;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  // squared radius, refreshed every cycle
  always_ff @(posedge clk_i) begin
    r2_q <= radius_q * radius_q;
  end

  // heading magnitudes and signs
  always_comb begin
    logic [2:0][31:0] h;
    h        = {in_word_i.heading_x, in_word_i.heading_y, in_word_i.heading_z};
    sa_d.o   = {in_word_i.origin_x, in_word_i.origin_y, in_word_i.origin_z};
    for (int i = 0; i < 3; i++) begin
      sa_d.neg[i] = h[i][31];
      sa_d.hm[i]  = h[i][31] ? 32'(-h[i]) : h[i];
    end
  end

  // prescale shift from the largest magnitude
  always_comb begin
    logic [31:0] mx;
    logic [4:0]  top;
    mx = sa_q.hm[0];
    if (sa_q.hm[1] > mx) mx = sa_q.hm[1];
    if (sa_q.hm[2] > mx) mx = sa_q.hm[2];
    top = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) top = 5'(i);
    end
    sb_d.o    = sa_q.o;
    sb_d.hm   = sa_q.hm;
    sb_d.neg  = sa_q.neg;
    sb_d.zero = (mx == '0);
    sb_d.sh   = (top < 5'd30) ? 5'd30 - top : 5'd0;
  end

  // apply the common shift
  always_comb begin
    sc_d.o    = sb_q.o;
    sc_d.neg  = sb_q.neg;
    sc_d.zero = sb_q.zero;
    for (int i = 0; i < 3; i++) begin
      sc_d.hn[i] = sb_q.hm[i] << sb_q.sh;
    end
  end

  // component squares
  always_comb begin
    sd_d.o    = sc_q.o;
    sd_d.hn   = sc_q.hn;
    sd_d.neg  = sc_q.neg;
    sd_d.zero = sc_q.zero;
    for (int i = 0; i < 3; i++) begin
      sd_d.sq[i] = sc_q.hn[i] * sc_q.hn[i];
    end
  end

  // sum of squares
  always_comb begin
    se_d.o    = sd_q.o;
    se_d.hn   = sd_q.hn;
    se_d.neg  = sd_q.neg;
    se_d.zero = sd_q.zero;
    sumsq_d   = sd_q.sq[0] + sd_q.sq[1] + sd_q.sq[2];
  end

  // heading length
  rsi_isqrt u_len_sqrt (
    .clk_i      (clk_i),
    .en_i       (adv),
    .radicand_i (sumsq_q),
    .root_o     (len)
  );

  // rounded dividends for the unit vector
  always_comb begin
    sf_d.len  = len;
    sf_d.o    = fr_dl_q[ROOT_STAGES-1].o;
    sf_d.neg  = fr_dl_q[ROOT_STAGES-1].neg;
    sf_d.zero = fr_dl_q[ROOT_STAGES-1].zero;
    for (int i = 0; i < 3; i++) begin
      sf_d.num[i] = {fr_dl_q[ROOT_STAGES-1].hn[i], 30'b0} + 62'(len >> 1);
    end
  end

  // unit vector components
  for (genvar i = 0; i < 3; i++) begin : g_unit
    rsi_div u_unit_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .numer_i (sf_q.num[i]),
      .denom_i (sf_q.len),
      .quot_o  (quot[i])
    );
  end

  // unit magnitudes and origin squares
  always_comb begin
    sg_d.umag = quot;
    sg_d.o    = dv_dl_q[DIV_STAGES-1].o;
    sg_d.neg  = dv_dl_q[DIV_STAGES-1].neg;
    sg_d.zero = dv_dl_q[DIV_STAGES-1].zero;
    for (int i = 0; i < 3; i++) begin
      sg_d.psq[i] = 64'($signed(sg_d.o[i]) * $signed(sg_d.o[i]));
    end
  end

  // origin times unit vector, and o.o
  always_comb begin
    logic signed [31:0] us;
    sh_d.umag = sg_q.umag;
    sh_d.o    = sg_q.o;
    sh_d.neg  = sg_q.neg;
    sh_d.zero = sg_q.zero;
    sh_d.p    = sg_q.psq[0] + sg_q.psq[1] + sg_q.psq[2];
    for (int i = 0; i < 3; i++) begin
      us = sg_q.neg[i] ? -$signed({1'b0, sg_q.umag[i]}) : $signed({1'b0, sg_q.umag[i]});
      sh_d.prod[i] = 64'($signed(sg_q.o[i]) * us);
    end
  end

  // dot product
  always_comb begin
    si_d.umag = sh_q.umag;
    si_d.o    = sh_q.o;
    si_d.neg  = sh_q.neg;
    si_d.zero = sh_q.zero;
    si_d.p    = sh_q.p;
    si_d.dot  = sh_q.prod[0] + sh_q.prod[1] + sh_q.prod[2];
  end

  // beta rounded half away from zero, magnitude clamped to 32 bits
  always_comb begin
    logic [63:0] dmag;
    logic [63:0] rnd;
    logic [33:0] dm;
    sj_d.umag = si_q.umag;
    sj_d.o    = si_q.o;
    sj_d.neg  = si_q.neg;
    sj_d.zero = si_q.zero;
    sj_d.p    = si_q.p;
    dmag      = si_q.dot[63] ? -si_q.dot : si_q.dot;
    rnd       = dmag + (64'd1 << (UNIT_FRAC - 1));
    dm        = rnd[UNIT_FRAC+33:UNIT_FRAC];
    sj_d.beta = si_q.dot[63] ? -{1'b0, dm} : {1'b0, dm};
    sj_d.bm   = (dm[33:32] != 2'b00) ? '1 : dm[31:0];
  end

  // beta squared
  always_comb begin
    sk_d.umag = sj_q.umag;
    sk_d.o    = sj_q.o;
    sk_d.neg  = sj_q.neg;
    sk_d.zero = sj_q.zero;
    sk_d.p    = sj_q.p;
    sk_d.beta = sj_q.beta;
    sk_d.q    = sj_q.bm * sj_q.bm;
  end

  // quarter discriminant, saturating
  always_comb begin
    logic [63:0] e;
    logic [64:0] s;
    logic [63:0] r2;
    r2        = {2'b00, r2_q};
    s         = '0;
    sl_d.umag = sk_q.umag;
    sl_d.o    = sk_q.o;
    sl_d.neg  = sk_q.neg;
    sl_d.beta = sk_q.beta;
    sl_d.miss = sk_q.zero;
    if (sk_q.q >= sk_q.p) begin
      e      = sk_q.q - sk_q.p;
      s      = {1'b0, r2} + {1'b0, e};
      sl_d.d = s[64] ? '1 : s[63:0];
    end else begin
      e      = sk_q.p - sk_q.q;
      sl_d.d = r2 - e;
      if (e > r2) sl_d.miss = 1'b1;
    end
  end

  // root of the discriminant
  rsi_isqrt u_disc_sqrt (
    .clk_i      (clk_i),
    .en_i       (adv),
    .radicand_i (sl_q.d),
    .root_o     (sq2)
  );

  // pick the nearer positive root
  always_comb begin
    logic signed [36:0] nb;
    logic signed [36:0] t1;
    logic signed [36:0] t2;
    bk_t                b;
    b         = bk_dl_q[ROOT_STAGES-1];
    nb        = -37'($signed(b.beta));
    t1        = nb - $signed({5'b0, sq2});
    t2        = nb + $signed({5'b0, sq2});
    sm_d.umag = b.umag;
    sm_d.o    = b.o;
    sm_d.neg  = b.neg;
    priority if (t1 > 0) begin
      sm_d.t   = t1[33:0];
      sm_d.hit = !b.miss;
    end else if (t2 > 0) begin
      sm_d.t   = t2[33:0];
      sm_d.hit = !b.miss;
    end else begin
      sm_d.t   = '0;
      sm_d.hit = 1'b0;
    end
  end

  // distance times unit components
  always_comb begin
    sn_d.o   = sm_q.o;
    sn_d.neg = sm_q.neg;
    sn_d.hit = sm_q.hit;
    for (int i = 0; i < 3; i++) begin
      sn_d.prod[i] = sm_q.t * sm_q.umag[i];
    end
  end

  // rounded offset, add to origin, saturate
  always_comb begin
    logic [64:0]        rnd;
    logic [34:0]        dm;
    logic signed [36:0] pt;
    logic [2:0][31:0]   res;
    for (int i = 0; i < 3; i++) begin
      rnd = sn_q.prod[i] + (65'd1 << (UNIT_FRAC - 1));
      dm  = rnd[64:UNIT_FRAC];
      pt  = 37'($signed(sn_q.o[i])) + (sn_q.neg[i] ? -$signed({2'b0, dm}) : $signed({2'b0, dm}));
      priority if (!sn_q.hit) begin
        res[i] = '0;
      end else if (pt > 37'sh0_7FFF_FFFF) begin
        res[i] = 32'h7FFF_FFFF;
      end else if (pt < -37'sh0_8000_0000) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = pt[31:0];
      end
    end
    out_d.hit     = sn_q.hit;
    out_d.point_x = res[2];
    out_d.point_y = res[1];
    out_d.point_z = res[0];
  end

  // payload registers, all advancing together
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      sc_q    <= sc_d;
      sd_q    <= sd_d;
      se_q    <= se_d;
      sumsq_q <= sumsq_d;
      fr_dl_q[0] <= se_q;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        fr_dl_q[k] <= fr_dl_q[k-1];
      end
      sf_q <= sf_d;
      dv_dl_q[0] <= '{o: sf_q.o, neg: sf_q.neg, zero: sf_q.zero};
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_dl_q[k] <= dv_dl_q[k-1];
      end
      sg_q <= sg_d;
      sh_q <= sh_d;
      si_q <= si_d;
      sj_q <= sj_d;
      sk_q <= sk_d;
      sl_q <= sl_d;
      bk_dl_q[0] <= '{beta: sl_q.beta, umag: sl_q.umag, o: sl_q.o, neg: sl_q.neg,
                      miss: sl_q.miss};
      for (int k = 1; k < ROOT_STAGES; k++) begin
        bk_dl_q[k] <= bk_dl_q[k-1];
      end
      sm_q  <= sm_d;
      sn_q  <= sn_d;
      out_q <= out_d;
    end
  end

endmodule

// File: test/ray_sphere_intersection_test.sv
`timescale 1ns / 1ps
// self-checking bench for the ray/sphere intersection pipeline
// depends on rsi_pkg and ray_sphere_intersection; predicts each hit word internally
module ray_sphere_intersection_test;
  import rsi_pkg::*;

  localparam int    DRAIN_CYCLES = 80;
  localparam longint R_ONE       = 65536;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  ray_t        in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  hit_t        out_word_o;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;

  // radius as the block holds it, words still owed by the block
  logic [30:0] radius_q = RADIUS_RESET;
  hit_t        owed_hits[$];
  int          fails = 0;
  bit          calm = 1'b0;

  ray_sphere_intersection u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // bitwise floor square root
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // expected hit word for one ray at the given radius
  function automatic hit_t trace_ray(ray_t r, logic [30:0] rad);
    longint          o[3], u[3], h, beta, t1, t2, t, dot, delta, pt;
    longint unsigned hm[3], m, sumsq, len, um, dm, bm, q, p, r2, d, e, prod;
    bit              hneg[3];
    hit_t            res;
    res = '0;
    o[0] = r.origin_x;  o[1] = r.origin_y;  o[2] = r.origin_z;
    for (int i = 0; i < 3; i++) begin
      h = (i == 0) ? longint'(r.heading_x) : (i == 1) ? longint'(r.heading_y)
                                                      : longint'(r.heading_z);
      hneg[i] = h < 0;
      hm[i] = mag(h);
    end
    m = hm[0];
    if (hm[1] > m) m = hm[1];
    if (hm[2] > m) m = hm[2];
    if (m == 0) return res;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) hm[i] <<= 1;
    end
    sumsq = hm[0] * hm[0] + hm[1] * hm[1] + hm[2] * hm[2];
    len = root64(sumsq);
    for (int i = 0; i < 3; i++) begin
      um = ((hm[i] << UNIT_FRAC) + (len >> 1)) / len;
      u[i] = hneg[i] ? -longint'(um) : longint'(um);
    end
    dot = o[0] * u[0] + o[1] * u[1] + o[2] * u[2];
    dm = (mag(dot) + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
    beta = dot < 0 ? -longint'(dm) : longint'(dm);
    bm = mag(beta);
    if (bm > 64'hFFFF_FFFF) bm = 64'hFFFF_FFFF;
    q = bm * bm;
    p = o[0] * o[0] + o[1] * o[1] + o[2] * o[2];
    r2 = longint'(rad) * longint'(rad);
    if (q >= p) begin
      e = q - p;
      d = (r2 > ~64'd0 - e) ? ~64'd0 : r2 + e;
    end else begin
      e = p - q;
      if (e > r2) return res;
      d = r2 - e;
    end
    t1 = -beta - longint'(root64(d));
    t2 = -beta + longint'(root64(d));
    if (t1 > 0) t = t1;
    else if (t2 > 0) t = t2;
    else return res;
    res.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      prod = longint'(t) * mag(u[i]);
      dm = (prod + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      delta = u[i] < 0 ? -longint'(dm) : longint'(dm);
      pt = o[i] + delta;
      if (pt > 64'sd2147483647) pt = 64'sd2147483647;
      if (pt < -64'sd2147483648) pt = -64'sd2147483648;
      if (i == 0) res.point_x = 32'(pt);
      else if (i == 1) res.point_y = 32'(pt);
      else res.point_z = 32'(pt);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one ray word and record its expected hit word on accept
  task automatic send_ray(ray_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    owed_hits.push_back(trace_ray(w, radius_q));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (owed_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [30:0] rad);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rad;
    radius_q    = rad;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return 32'(v);
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'hFFFF_FFFF)) % (span + 1) *
           ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  function automatic ray_t make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                    logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    ray_t w;
    w.origin_x = ox;  w.origin_y = oy;  w.origin_z = oz;
    w.heading_x = hx; w.heading_y = hy; w.heading_z = hz;
    return w;
  endfunction

  // random ray: aimed at the sphere mostly, otherwise fully random, degenerate or near the center with a random heading
  function automatic ray_t random_ray();
    longint span, ox, oy, oz;
    int     kind;
    ray_t   w;
    kind = $urandom_range(0, 99);
    span = (radius_q == 0) ? R_ONE : longint'(radius_q) * 4;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    ox = spread(span);  oy = spread(span);  oz = spread(span);
    if (kind < 15) begin
      w = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 18) begin
      w = make_ray(clamp32(ox), clamp32(oy), clamp32(oz), 0, 0, 0);
    end else if (kind < 30) begin
      w = make_ray(clamp32(ox / 4), clamp32(oy / 4), clamp32(oz / 4),
                   $urandom, $urandom, $urandom);
    end else begin
      w = make_ray(clamp32(ox), clamp32(oy), clamp32(oz),
                   clamp32(-ox + spread(span / 4)), clamp32(-oy + spread(span / 4)),
                   clamp32(-oz + spread(span / 4)));
    end
    return w;
  endfunction

  // check each hit word and drive random output stalls
  always @(posedge clk_i) begin : hit_check
    hit_t want;
    int   r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_hits.size() == 0) begin
        report_mismatch("unexpected word", out_word_o.point_x, 32'h0);
      end else begin
        want = owed_hits.pop_front();
        if (out_word_o.hit !== want.hit)
          report_mismatch("hit", 32'(out_word_o.hit), 32'(want.hit));
        if (out_word_o.point_x !== want.point_x)
          report_mismatch("point_x", out_word_o.point_x, want.point_x);
        if (out_word_o.point_y !== want.point_y)
          report_mismatch("point_y", out_word_o.point_y, want.point_y);
        if (out_word_o.point_z !== want.point_z)
          report_mismatch("point_z", out_word_o.point_z, want.point_z);
      end
    end
    r = $urandom_range(0, 99);
    if (calm) out_stall_i <= 1'b0;
    else if (out_stall_i) out_stall_i <= (r < 70);
    else out_stall_i <= (r < 12);
  end

  task automatic test_corner_rays();
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, 32'h0001_0000, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 32'h8000_0000));
    send_ray(make_ray(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(make_ray(0, 0, 0, 1, 0, 0));
    // tangent ray grazing the sphere
    send_ray(make_ray(32'h0001_0000, 32'hFFFB_0000, 0, 0, 32'h0001_0000, 0));
    // sphere behind the origin
    send_ray(make_ray(0, 0, 32'h0005_0000, 0, 0, 32'h0001_0000));
    // head-on from outside
    send_ray(make_ray(0, 0, 32'h0005_0000, 0, 0, 32'hFFFF_0000));
    // far origin aimed back through the center
    send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(make_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_ray(make_ray(32'h0000_8000, 32'hFFFF_8000, 0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF));
  endtask

  task automatic test_radius_extremes();
    set_radius(31'h7FFF_FFFF);
    test_corner_rays();
    set_radius('0);
    send_ray(make_ray(0, 0, 0, 0, 0, 32'h0001_0000));
    send_ray(make_ray(0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_0000));
    send_ray(make_ray(0, 32'h0002_0000, 0, 0, 32'hFFFF_FFFF, 0));
  endtask

  task automatic test_random_rays(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i % 200) >= 170;
      if (i == count / 2) drain();
      send_ray(random_ray());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_rays();
    test_radius_extremes();
    set_radius(31'(R_ONE));
    test_random_rays(330);
    set_radius(31'($urandom));
    test_random_rays(330);
    set_radius(31'h7FFF_FFFF);
    test_random_rays(330);
    set_radius(31'($urandom_range(1, 255)));
    test_random_rays(330);
    set_radius(31'(R_ONE * 100));
    test_random_rays(330);
    drain();
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
